// File: rtl/core/necir_pkg.sv
// Shared types and constants for the NEC infrared frame decoder.
// Used by necir_symbol_match and nec_ir_frame_decoder_unit; depends on nothing.
package necir_pkg;

   localparam int TICK_W     = 15;
   localparam int COUNT_W    = 9;
   localparam int BYTES_W    = 6;
   localparam int STATUS_W   = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int MARGIN_MAX = 4095;

   localparam logic [COUNT_W-1:0] COUNT_MAX        = 9'd511;
   localparam logic [COUNT_W-1:0] HEADER_SYMBOLS   = 9'd17;
   localparam logic [COUNT_W-1:0] STANDARD_SYMBOLS = 9'd34;
   localparam logic [COUNT_W-1:0] REPEAT_SYMBOLS   = 9'd2;
   localparam int                 GROUP_SYMBOLS    = 8;
   localparam int                 GROUP_BIT_W      = $clog2(GROUP_SYMBOLS);

   localparam int DEF_DECODE_MARGIN  = 200;
   localparam int DEF_MAX_DATA_BYTES = 32;

   localparam logic [TICK_W-1:0] RST_LEADER_MARK  = 15'd9000;
   localparam logic [TICK_W-1:0] RST_LEADER_SPACE = 15'd4500;
   localparam logic [TICK_W-1:0] RST_ZERO_MARK    = 15'd560;
   localparam logic [TICK_W-1:0] RST_ZERO_SPACE   = 15'd560;
   localparam logic [TICK_W-1:0] RST_ONE_MARK     = 15'd560;
   localparam logic [TICK_W-1:0] RST_ONE_SPACE    = 15'd1690;
   localparam logic [TICK_W-1:0] RST_REPEAT_MARK  = 15'd9000;
   localparam logic [TICK_W-1:0] RST_REPEAT_SPACE = 15'd2250;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LEADER_MARK  = 3'd0,
      CSR_LEADER_SPACE = 3'd1,
      CSR_ZERO_MARK    = 3'd2,
      CSR_ZERO_SPACE   = 3'd3,
      CSR_ONE_MARK     = 3'd4,
      CSR_ONE_SPACE    = 3'd5,
      CSR_REPEAT_MARK  = 3'd6,
      CSR_REPEAT_SPACE = 3'd7
   } csr_index_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_STANDARD   = 4'd0,
      ST_EXTENDED   = 4'd1,
      ST_REPEAT     = 4'd2,
      ST_BAD_REPEAT = 4'd3,
      ST_SHORT      = 4'd4,
      ST_BAD_LEADER = 4'd5,
      ST_BAD_ADDR   = 4'd6,
      ST_NO_DATA    = 4'd7,
      ST_TOO_MANY   = 4'd8,
      ST_BAD_DATA   = 4'd9
   } status_type;

   typedef struct packed {
      logic [TICK_W-1:0] leader_mark;
      logic [TICK_W-1:0] leader_space;
      logic [TICK_W-1:0] zero_mark;
      logic [TICK_W-1:0] zero_space;
      logic [TICK_W-1:0] one_mark;
      logic [TICK_W-1:0] one_space;
      logic [TICK_W-1:0] repeat_mark;
      logic [TICK_W-1:0] repeat_space;
   } timing_type;

   typedef struct packed {
      logic leader_hit;
      logic rpt_hit;
      logic one_hit;
      logic zero_hit;
   } match_type;

endpackage

// File: rtl/core/necir_symbol_match.sv
// Tolerance-window compare of one symbol against the four timing pairs.
// Depends on necir_pkg for the timing and match structs.
module necir_symbol_match #(
   parameter int DECODE_MARGIN = necir_pkg::DEF_DECODE_MARGIN
) (
   input  logic [necir_pkg::TICK_W-1:0] mark_ticks,
   input  logic [necir_pkg::TICK_W-1:0] space_ticks,
   input  necir_pkg::timing_type        timing,
   output necir_pkg::match_type         hit
);

   localparam int SUM_W = necir_pkg::TICK_W + 1;
   localparam logic [SUM_W-1:0] MARGIN = SUM_W'(DECODE_MARGIN);

   function automatic logic in_window(input logic [necir_pkg::TICK_W-1:0] d,
                                      input logic [necir_pkg::TICK_W-1:0] e);
      logic [SUM_W-1:0] d_w;
      logic [SUM_W-1:0] e_w;
      d_w = {1'b0, d};
      e_w = {1'b0, e};
      return (d_w < e_w + MARGIN) && (d_w + MARGIN > e_w);
   endfunction

   always_comb begin
      hit.leader_hit = in_window(mark_ticks, timing.leader_mark)
                       && in_window(space_ticks, timing.leader_space);
      hit.rpt_hit    = in_window(mark_ticks, timing.repeat_mark)
                       && in_window(space_ticks, timing.repeat_space);
      hit.one_hit    = in_window(mark_ticks, timing.one_mark)
                       && in_window(space_ticks, timing.one_space);
      hit.zero_hit   = in_window(mark_ticks, timing.zero_mark)
                       && in_window(space_ticks, timing.zero_space);
   end

endmodule

// File: rtl/core/nec_ir_frame_decoder_unit.sv
// Top level of the NEC infrared frame decoder: input stage, symbol decode, result stage.
// Depends on necir_pkg and necir_symbol_match.
//
// Usage: each req_ word is one received pulse symbol (mark and space in ticks) with
// req_frame_end set on the last symbol of a frame. Symbols without frame end give no
// rsp_ word; the symbol with frame end gives exactly one rsp_ word carrying status,
// address, command, repeat flag and data byte count.
// Path: an accepted word sits in the input register; it is decoded there and its result
// is registered in the result register, which drives rsp_valid.
// Throughput: one symbol per cycle, set by the single decode pass between the input
// register and the result register; a frame-end symbol waits while a result is held.
// Stall: while a result is held unaccepted, symbols without frame end keep flowing;
// a frame-end symbol waits in the input register and req_ready drops behind it.
// Reset: synchronous, active high; clears frame state, remembered address and command,
// empties both registers and loads the default timing values. Timing registers are
// written through csr_we/csr_index/csr_wdata only while idle; a user rule, not enforced.
module nec_ir_frame_decoder_unit #(
   parameter int DECODE_MARGIN  = necir_pkg::DEF_DECODE_MARGIN,
   parameter int MAX_DATA_BYTES = necir_pkg::DEF_MAX_DATA_BYTES
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [necir_pkg::TICK_W-1:0]     req_mark_ticks,
   input  logic [necir_pkg::TICK_W-1:0]     req_space_ticks,
   input  logic                             req_frame_end,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [necir_pkg::STATUS_W-1:0]   rsp_status,
   output logic [15:0]                      rsp_address_out,
   output logic [15:0]                      rsp_command_out,
   output logic                             rsp_is_repeat,
   output logic [necir_pkg::BYTES_W-1:0]    rsp_data_byte_count,
   input  logic                             csr_we,
   input  logic [necir_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [necir_pkg::TICK_W-1:0]     csr_wdata
);

   localparam int CW  = necir_pkg::COUNT_W;
   localparam int BW  = necir_pkg::BYTES_W;
   localparam int GBW = necir_pkg::GROUP_BIT_W;

   necir_pkg::timing_type timing_ff;

   logic                        in_valid_ff;
   logic [necir_pkg::TICK_W-1:0] in_mark_ff;
   logic [necir_pkg::TICK_W-1:0] in_space_ff;
   logic                        in_end_ff;

   logic [CW-1:0] sym_count_ff,   sym_count_in;
   logic          leader_ok_ff,   leader_ok_in;
   logic          repeat_ok_ff,   repeat_ok_in;
   logic [15:0]   addr_shift_ff,  addr_shift_in;
   logic          addr_error_ff,  addr_error_in;
   logic [7:0]    byte_shift_ff,  byte_shift_in;
   logic          group_error_ff, group_error_in;
   logic          data_error_ff,  data_error_in;
   logic [7:0]    first_byte_ff,  first_byte_in;
   logic [7:0]    second_byte_ff, second_byte_in;
   logic [15:0]   rem_addr_ff,    rem_addr_in;
   logic [15:0]   rem_cmd_ff,     rem_cmd_in;

   logic                  rsp_valid_ff,  rsp_valid_in;
   necir_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [15:0]           rsp_addr_ff,   rsp_addr_in;
   logic [15:0]           rsp_cmd_ff,    rsp_cmd_in;
   logic                  rsp_rep_ff,    rsp_rep_in;
   logic [BW-1:0]         rsp_cnt_ff,    rsp_cnt_in;

   necir_pkg::match_type hit;
   logic                 advance;
   logic                 sym_ok;
   logic [CW-1:0]        pos;
   logic [GBW-1:0]       grp_bit;
   logic [CW-GBW-1:0]    grp_num;
   logic [3:0]           addr_idx;
   logic [CW-1:0]        frame_len;
   logic [BW-1:0]        n_bytes;

   necir_symbol_match #(
      .DECODE_MARGIN (DECODE_MARGIN)
   ) u_match (
      .mark_ticks  (in_mark_ff),
      .space_ticks (in_space_ff),
      .timing      (timing_ff),
      .hit         (hit)
   );

   assign advance   = in_valid_ff && (!in_end_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign sym_ok    = hit.one_hit || hit.zero_hit;
   assign pos       = sym_count_ff - necir_pkg::HEADER_SYMBOLS;
   assign grp_bit   = pos[GBW-1:0];
   assign grp_num   = pos[CW-1:GBW];
   assign addr_idx  = 4'(sym_count_ff - CW'(1));
   assign frame_len = (sym_count_ff == necir_pkg::COUNT_MAX) ? sym_count_ff
                                                            : sym_count_ff + CW'(1);
   assign n_bytes   = BW'((frame_len - necir_pkg::HEADER_SYMBOLS)
                          / necir_pkg::GROUP_SYMBOLS);

   always_ff @(posedge clock) begin
      if (reset) begin
         timing_ff.leader_mark  <= necir_pkg::RST_LEADER_MARK;
         timing_ff.leader_space <= necir_pkg::RST_LEADER_SPACE;
         timing_ff.zero_mark    <= necir_pkg::RST_ZERO_MARK;
         timing_ff.zero_space   <= necir_pkg::RST_ZERO_SPACE;
         timing_ff.one_mark     <= necir_pkg::RST_ONE_MARK;
         timing_ff.one_space    <= necir_pkg::RST_ONE_SPACE;
         timing_ff.repeat_mark  <= necir_pkg::RST_REPEAT_MARK;
         timing_ff.repeat_space <= necir_pkg::RST_REPEAT_SPACE;
      end else if (csr_we) begin
         case (necir_pkg::csr_index_type'(csr_index))
            necir_pkg::CSR_LEADER_MARK:  timing_ff.leader_mark  <= csr_wdata;
            necir_pkg::CSR_LEADER_SPACE: timing_ff.leader_space <= csr_wdata;
            necir_pkg::CSR_ZERO_MARK:    timing_ff.zero_mark    <= csr_wdata;
            necir_pkg::CSR_ZERO_SPACE:   timing_ff.zero_space   <= csr_wdata;
            necir_pkg::CSR_ONE_MARK:     timing_ff.one_mark     <= csr_wdata;
            necir_pkg::CSR_ONE_SPACE:    timing_ff.one_space    <= csr_wdata;
            necir_pkg::CSR_REPEAT_MARK:  timing_ff.repeat_mark  <= csr_wdata;
            necir_pkg::CSR_REPEAT_SPACE: timing_ff.repeat_space <= csr_wdata;
            default:                     timing_ff <= timing_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         in_mark_ff  <= req_mark_ticks;
         in_space_ff <= req_space_ticks;
         in_end_ff   <= req_frame_end;
      end
   end

   always_comb begin
      sym_count_in   = sym_count_ff;
      leader_ok_in   = leader_ok_ff;
      repeat_ok_in   = repeat_ok_ff;
      addr_shift_in  = addr_shift_ff;
      addr_error_in  = addr_error_ff;
      byte_shift_in  = byte_shift_ff;
      group_error_in = group_error_ff;
      data_error_in  = data_error_ff;
      first_byte_in  = first_byte_ff;
      second_byte_in = second_byte_ff;
      rem_addr_in    = rem_addr_ff;
      rem_cmd_in     = rem_cmd_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_addr_in    = rsp_addr_ff;
      rsp_cmd_in     = rsp_cmd_ff;
      rsp_rep_in     = rsp_rep_ff;
      rsp_cnt_in     = rsp_cnt_ff;

      if (advance && sym_count_ff != necir_pkg::COUNT_MAX) begin
         if (sym_count_ff == '0) begin
            leader_ok_in = hit.leader_hit;
            repeat_ok_in = hit.rpt_hit;
         end else if (sym_count_ff < necir_pkg::HEADER_SYMBOLS) begin
            if (hit.one_hit) begin
               addr_shift_in[addr_idx] = 1'b1;
            end
            if (!sym_ok) begin
               addr_error_in = 1'b1;
            end
         end else begin
            if (grp_bit == '0) begin
               byte_shift_in  = '0;
               group_error_in = 1'b0;
            end
            if (hit.one_hit) begin
               byte_shift_in[grp_bit] = 1'b1;
            end
            if (!sym_ok) begin
               group_error_in = 1'b1;
            end
            if (grp_bit == '1) begin
               if (group_error_in) begin
                  data_error_in = 1'b1;
               end
               if (grp_num == '0) begin
                  first_byte_in = byte_shift_in;
               end else if (grp_num == (CW-GBW)'(1)) begin
                  second_byte_in = byte_shift_in;
               end
            end
         end
         sym_count_in = sym_count_ff + CW'(1);
      end

      if (advance && in_end_ff) begin
         rsp_valid_in  = 1'b1;
         rsp_addr_in   = '0;
         rsp_cmd_in    = '0;
         rsp_rep_in    = 1'b0;
         rsp_cnt_in    = '0;
         if (sym_count_in == necir_pkg::REPEAT_SYMBOLS) begin
            if (repeat_ok_in) begin
               rsp_status_in = necir_pkg::ST_REPEAT;
               rsp_addr_in   = rem_addr_ff;
               rsp_cmd_in    = rem_cmd_ff;
               rsp_rep_in    = 1'b1;
            end else begin
               rsp_status_in = necir_pkg::ST_BAD_REPEAT;
            end
         end else if (sym_count_in < necir_pkg::HEADER_SYMBOLS) begin
            rsp_status_in = necir_pkg::ST_SHORT;
         end else if (!leader_ok_in) begin
            rsp_status_in = necir_pkg::ST_BAD_LEADER;
         end else if (addr_error_in) begin
            rsp_status_in = necir_pkg::ST_BAD_ADDR;
         end else if (n_bytes == '0) begin
            rsp_status_in = necir_pkg::ST_NO_DATA;
         end else if (n_bytes > BW'(MAX_DATA_BYTES)) begin
            rsp_status_in = necir_pkg::ST_TOO_MANY;
         end else if (data_error_in) begin
            rsp_status_in = necir_pkg::ST_BAD_DATA;
         end else begin
            rsp_addr_in = addr_shift_in;
            rsp_cnt_in  = n_bytes;
            if (sym_count_in == necir_pkg::STANDARD_SYMBOLS) begin
               rsp_status_in = necir_pkg::ST_STANDARD;
               rsp_cmd_in    = {second_byte_in, first_byte_in};
            end else begin
               rsp_status_in = necir_pkg::ST_EXTENDED;
               rsp_cmd_in    = {8'd0, first_byte_in};
            end
            rem_addr_in = rsp_addr_in;
            rem_cmd_in  = rsp_cmd_in;
         end

         // drop per-frame state
         sym_count_in   = '0;
         leader_ok_in   = 1'b0;
         repeat_ok_in   = 1'b0;
         addr_shift_in  = '0;
         addr_error_in  = 1'b0;
         byte_shift_in  = '0;
         group_error_in = 1'b0;
         data_error_in  = 1'b0;
         first_byte_in  = '0;
         second_byte_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sym_count_ff   <= '0;
         leader_ok_ff   <= 1'b0;
         repeat_ok_ff   <= 1'b0;
         addr_shift_ff  <= '0;
         addr_error_ff  <= 1'b0;
         byte_shift_ff  <= '0;
         group_error_ff <= 1'b0;
         data_error_ff  <= 1'b0;
         first_byte_ff  <= '0;
         second_byte_ff <= '0;
         rem_addr_ff    <= '0;
         rem_cmd_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         sym_count_ff   <= sym_count_in;
         leader_ok_ff   <= leader_ok_in;
         repeat_ok_ff   <= repeat_ok_in;
         addr_shift_ff  <= addr_shift_in;
         addr_error_ff  <= addr_error_in;
         byte_shift_ff  <= byte_shift_in;
         group_error_ff <= group_error_in;
         data_error_ff  <= data_error_in;
         first_byte_ff  <= first_byte_in;
         second_byte_ff <= second_byte_in;
         rem_addr_ff    <= rem_addr_in;
         rem_cmd_ff     <= rem_cmd_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_cmd_ff    <= rsp_cmd_in;
      rsp_rep_ff    <= rsp_rep_in;
      rsp_cnt_ff    <= rsp_cnt_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_address_out     = rsp_addr_ff;
   assign rsp_command_out     = rsp_cmd_ff;
   assign rsp_is_repeat       = rsp_rep_ff;
   assign rsp_data_byte_count = rsp_cnt_ff;

   a_frame_end_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && in_end_ff) |=> (sym_count_ff == '0 && !addr_error_ff && !data_error_ff))
      else $error("frame state not cleared after frame end");

   a_end_waits_on_stall: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && in_end_ff && rsp_valid_ff && !rsp_ready) |-> !advance)
      else $error("frame-end word overran a held result");

   a_repeat_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_repeat) |-> (rsp_status_ff == necir_pkg::ST_REPEAT))
      else $error("repeat flag without repeat status");

   a_count_only_on_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data_byte_count != '0) |->
         (rsp_status_ff == necir_pkg::ST_STANDARD || rsp_status_ff == necir_pkg::ST_EXTENDED))
      else $error("byte count on a non-data result");

   a_standard_two_bytes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status_ff == necir_pkg::ST_STANDARD) |-> (rsp_data_byte_count == BW'(2)))
      else $error("standard frame without two data bytes");

   a_remember_on_success: assert property (@(posedge clock) disable iff (reset)
      (advance && in_end_ff && (rsp_status_in == necir_pkg::ST_STANDARD
                                || rsp_status_in == necir_pkg::ST_EXTENDED))
      |=> (rem_addr_ff == rsp_addr_ff && rem_cmd_ff == rsp_cmd_ff))
      else $error("remembered address or command not updated");

endmodule
